// File: hdl/ebd_pkg.sv
// ----------------------------------------------------------------------------
// ebd_pkg: shared types and constants of the energy beat detector
// Register indexes, reset values, and the command/status types of the
// bit-serial multiply-accumulate unit.
// ----------------------------------------------------------------------------
package ebd_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned COEF_W    = 13;
    localparam int unsigned Q_BITS    = 12;
    localparam int unsigned MAC_W     = 41;
    localparam int unsigned MAC_STEPS = 13;
    localparam int unsigned CNT_W     = $clog2(MAC_STEPS);
    localparam int unsigned IDX_W     = 3;

    localparam logic [Q_BITS-1:0] ROUND_HALF = 12'h800;

    localparam logic [IDX_W-1:0] REG_FAST_COEF     = 3'd0;
    localparam logic [IDX_W-1:0] REG_SLOW_COEF     = 3'd1;
    localparam logic [IDX_W-1:0] REG_INTERVAL_COEF = 3'd2;
    localparam logic [IDX_W-1:0] REG_RATIO_THR     = 3'd3;
    localparam logic [IDX_W-1:0] REG_HOLDOFF_LEN   = 3'd4;
    localparam logic [IDX_W-1:0] REG_STEADY_LIMIT  = 3'd5;
    localparam logic [IDX_W-1:0] REG_BLINK_PERIOD  = 3'd6;

    localparam logic [COEF_W-1:0] RST_FAST_COEF     = 13'd10;
    localparam logic [COEF_W-1:0] RST_SLOW_COEF     = 13'd4095;
    localparam logic [COEF_W-1:0] RST_INTERVAL_COEF = 13'd1024;
    localparam logic [7:0]        RST_RATIO_THR     = 8'd4;
    localparam logic [15:0]       RST_HOLDOFF_LEN   = 16'd1500;
    localparam logic [DATA_W-1:0] RST_STEADY_LIMIT  = 32'd300;
    localparam logic [7:0]        RST_BLINK_PERIOD  = 8'd99;

    typedef struct packed {
        logic              start;
        logic [MAC_W-1:0]  acc_init;
        logic [MAC_W-1:0]  mcand;
        logic [COEF_W-1:0] mplier;
    } t_mac_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mac_stat;

endpackage

// File: hdl/ebd_mac.sv
// ----------------------------------------------------------------------------
// ebd_mac: bit-serial multiply-accumulate
// Adds multiplicand times multiplier to a preset accumulator, consuming one
// multiplier bit per cycle while the multiplicand shifts left.
// ----------------------------------------------------------------------------
module ebd_mac
    import ebd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mac_cmd         i_cmd,
    output t_mac_stat        o_stat,
    output logic [MAC_W-1:0] o_acc
);

    logic [MAC_W-1:0]  r_acc;
    logic [MAC_W-1:0]  r_mcand;
    logic [COEF_W-1:0] r_mplier;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MAC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc    <= i_cmd.acc_init;
            r_mcand  <= i_cmd.mcand;
            r_mplier <= i_cmd.mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[MAC_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[COEF_W-1:1]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_acc       = r_acc;

endmodule

// File: hdl/energy_beat_detector.sv
// ----------------------------------------------------------------------------
// energy_beat_detector: energy-ratio beat detector with Q12 averages
// Sequencing: a sample transaction takes three serial MAC passes (slow
//   average, fast average, ratio compare) and two more on a beat (mean
//   interval, mean error); a tick uses no MAC pass.
// Flow: the next transaction is taken once the result registers and the
//   state returns to idle. A new transaction is taken while the previous
//   result still waits.
// Reset: synchronous active-low; averages and counters clear, registers load
//   their default values.
// ----------------------------------------------------------------------------
module energy_beat_detector
    import ebd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_mode,
    input  logic [7:0]        i_sample,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_beat,
    output logic [DATA_W-1:0] o_interval,
    output logic [DATA_W-1:0] o_mean_interval,
    output logic [DATA_W-1:0] o_mean_error,
    output logic              o_led
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOW,
        S_FAST,
        S_CMP,
        S_IMGO,
        S_IM,
        S_ABS,
        S_ERRGO,
        S_ERR,
        S_OUT
    } t_state;

    localparam int unsigned EXT_W = MAC_W - DATA_W;

    t_state            r_state;
    t_mac_cmd          r_cmd;
    t_mac_stat         w_stat;
    logic [MAC_W-1:0]  w_acc;

    logic [COEF_W-1:0] r_fast_coef;
    logic [COEF_W-1:0] r_slow_coef;
    logic [COEF_W-1:0] r_interval_coef;
    logic [7:0]        r_ratio_thr;
    logic [15:0]       r_holdoff_len;
    logic [DATA_W-1:0] r_steady_limit;
    logic [7:0]        r_blink_period;

    logic [DATA_W-1:0] r_slow;
    logic [DATA_W-1:0] r_fast;
    logic [DATA_W-1:0] r_im;
    logic [DATA_W-1:0] r_err;
    logic [15:0]       r_holdoff;
    logic [DATA_W-1:0] r_tick;
    logic [DATA_W-1:0] r_last;
    logic [7:0]        r_blink;
    logic [7:0]        r_s8;
    logic [DATA_W-1:0] r_interval;
    logic [DATA_W-1:0] r_dev;
    logic              r_beat;
    logic              r_ov;

    logic [DATA_W-1:0] w_s_in;
    logic [DATA_W-1:0] w_s_reg;
    logic [DATA_W-1:0] w_ema;
    logic              w_hit;
    logic [7:0]        w_blink_inc;
    logic [7:0]        w_top;
    logic [7:0]        w_blink_next;

    ebd_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_cmd),
        .o_stat  (w_stat),
        .o_acc   (w_acc)
    );

    assign w_s_in       = {12'b0, i_sample, 12'b0};
    assign w_s_reg      = {12'b0, r_s8, 12'b0};
    assign w_ema        = {12'b0, w_acc[DATA_W-1:Q_BITS]};
    assign w_hit        = (r_slow == '0) ? (r_fast != '0)
                                         : ({EXT_W'(0), r_fast} >= w_acc);
    assign w_blink_inc  = r_blink + 8'd1;
    assign w_top        = (r_err < r_steady_limit) ? r_blink_period : 8'd0;
    assign w_blink_next = (w_blink_inc > w_top) ? 8'd0 : w_blink_inc;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_coef     <= RST_FAST_COEF;
            r_slow_coef     <= RST_SLOW_COEF;
            r_interval_coef <= RST_INTERVAL_COEF;
            r_ratio_thr     <= RST_RATIO_THR;
            r_holdoff_len   <= RST_HOLDOFF_LEN;
            r_steady_limit  <= RST_STEADY_LIMIT;
            r_blink_period  <= RST_BLINK_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FAST_COEF:     r_fast_coef     <= i_cfg_data[COEF_W-1:0];
                REG_SLOW_COEF:     r_slow_coef     <= i_cfg_data[COEF_W-1:0];
                REG_INTERVAL_COEF: r_interval_coef <= i_cfg_data[COEF_W-1:0];
                REG_RATIO_THR:     r_ratio_thr     <= i_cfg_data[7:0];
                REG_HOLDOFF_LEN:   r_holdoff_len   <= i_cfg_data[15:0];
                REG_STEADY_LIMIT:  r_steady_limit  <= i_cfg_data;
                REG_BLINK_PERIOD:  r_blink_period  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmd     <= '0;
            r_ov      <= 1'b0;
            r_slow    <= '0;
            r_fast    <= '0;
            r_im      <= '0;
            r_err     <= '0;
            r_holdoff <= '0;
            r_tick    <= '0;
            r_last    <= '0;
            r_blink   <= '0;
            r_beat    <= 1'b0;
        end else begin
            r_cmd.start <= 1'b0;
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_mode) begin
                            r_tick     <= r_tick + 32'd1;
                            r_blink    <= w_blink_next;
                            r_beat     <= 1'b0;
                            r_interval <= '0;
                            r_state    <= S_OUT;
                        end else begin
                            r_s8           <= i_sample;
                            r_cmd.start    <= 1'b1;
                            r_cmd.acc_init <= MAC_W'({i_sample, 12'b0, ROUND_HALF});
                            r_cmd.mcand    <= MAC_W'(r_slow - w_s_in);
                            r_cmd.mplier   <= r_slow_coef;
                            r_state        <= S_SLOW;
                        end
                    end
                end
                S_SLOW: begin
                    if (w_stat.done) begin
                        r_slow         <= w_ema;
                        r_cmd.start    <= 1'b1;
                        r_cmd.acc_init <= MAC_W'({r_s8, 12'b0, ROUND_HALF});
                        r_cmd.mcand    <= MAC_W'(r_fast - w_s_reg);
                        r_cmd.mplier   <= r_fast_coef;
                        r_state        <= S_FAST;
                    end
                end
                S_FAST: begin
                    if (w_stat.done) begin
                        r_fast         <= w_ema;
                        r_cmd.start    <= 1'b1;
                        r_cmd.acc_init <= '0;
                        r_cmd.mcand    <= MAC_W'(r_slow);
                        r_cmd.mplier   <= COEF_W'(r_ratio_thr) + COEF_W'(1);
                        r_state        <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_stat.done) begin
                        if (w_hit && (r_holdoff == '0)) begin
                            r_beat     <= 1'b1;
                            r_interval <= r_tick - r_last;
                            r_last     <= r_tick;
                            r_holdoff  <= (r_holdoff_len != '0) ? r_holdoff_len - 16'd1
                                                                : 16'd0;
                            r_state    <= S_IMGO;
                        end else begin
                            r_beat     <= 1'b0;
                            r_interval <= '0;
                            if (r_holdoff != '0) begin
                                r_holdoff <= r_holdoff - 16'd1;
                            end
                            r_state    <= S_OUT;
                        end
                    end
                end
                S_IMGO: begin
                    r_cmd.start    <= 1'b1;
                    r_cmd.acc_init <= MAC_W'({r_interval[DATA_W-Q_BITS-1:0], ROUND_HALF});
                    r_cmd.mcand    <= MAC_W'(r_im - r_interval);
                    r_cmd.mplier   <= r_interval_coef;
                    r_state        <= S_IM;
                end
                S_IM: begin
                    if (w_stat.done) begin
                        r_im    <= w_ema;
                        r_dev   <= w_ema - r_interval;
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_dev   <= r_dev[DATA_W-1] ? (32'd0 - r_dev) : r_dev;
                    r_state <= S_ERRGO;
                end
                S_ERRGO: begin
                    r_cmd.start    <= 1'b1;
                    r_cmd.acc_init <= MAC_W'({r_dev[DATA_W-Q_BITS-1:0], ROUND_HALF});
                    r_cmd.mcand    <= MAC_W'(r_err - r_dev);
                    r_cmd.mplier   <= r_interval_coef;
                    r_state        <= S_ERR;
                end
                S_ERR: begin
                    if (w_stat.done) begin
                        r_err   <= w_ema;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ov || !i_out_stall) begin
                        r_ov            <= 1'b1;
                        o_beat          <= r_beat;
                        o_interval      <= r_interval;
                        o_mean_interval <= r_im;
                        o_mean_error    <= r_err;
                        o_led           <= (r_blink == '0);
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_state == S_SLOW || r_state == S_FAST || r_state == S_CMP
                         || r_state == S_IM || r_state == S_ERR))
        else $error("MAC completion outside a wait state");

    a_start_idle_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.start |-> !w_stat.busy)
        else $error("MAC started while busy");

    a_no_beat_zero_intv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_beat) |-> (o_interval == '0))
        else $error("nonzero interval without beat");

    a_holdoff_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && w_stat.done && r_holdoff != '0)
            |=> (r_state == S_OUT && !r_beat))
        else $error("beat fired during holdoff");

endmodule
